// ===== src/gpb_pkg.sv =====
package gpb_pkg;

    // Result codes, carried on m_tuser
    typedef enum logic [2:0] {
        ST_BINNED  = 3'd0,
        ST_OUTSIDE = 3'd1,
        ST_SKIPPED = 3'd2,
        ST_GAP     = 3'd3,
        ST_STARTED = 3'd4
    } status_t;

    // Register indexes on the configuration channel
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORTH    = 3'd0,
        REG_SOUTH    = 3'd1,
        REG_WEST     = 3'd2,
        REG_EAST     = 3'd3,
        REG_ROWS     = 3'd4,
        REG_COLS     = 3'd5,
        REG_EXCL_LAT = 3'd6,
        REG_EXCL_LNG = 3'd7
    } cfg_reg_t;

    // Field widths fixed by the interface
    localparam int COORD_W  = 32;
    localparam int GRID_W   = 5;   // row/column count and search index
    localparam int ACC_W    = 39;  // edge accumulator: lo + 31*step fits
    localparam int IN_W     = 72;
    localparam int OUT_W    = 32;
    localparam int ROWF_W   = 4;
    localparam int OCNT_W   = 16;
    localparam int DIV_CNT_W = 5;  // 32 quotient bits, one per cycle

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_CLR_STEP,
        OP_SRCH_STEP,
        OP_MEM_RD,
        OP_MEM_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_status;
        status_t status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic clr_last;
        logic in_box;
        logic skip;
        logic srch_done;
        logic gap;
    } dp_stat_t;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_WRITE,
        S_DIV,
        S_CLEAR,
        S_DONE
    } ctrl_state_t;

endpackage

// ===== src/gpb_ctrl.sv =====
module gpb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_action,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gpb_pkg::dp_cmd_t  cmd,
    input  gpb_pkg::dp_stat_t stat
);
    import gpb_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.set_status = 1'b0;
        cmd.status     = ST_BINNED;
        cmd.out_load   = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_CLR_STEP;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = s_action ? S_DIV : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.in_box)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OUTSIDE;
                    state_next     = S_DONE;
                end
                else if (stat.skip)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_SKIPPED;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!stat.srch_done)
                begin
                    cmd.op = OP_SRCH_STEP;
                end
                else if (stat.gap)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_GAP;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_MEM_RD;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.op         = OP_MEM_WR;
                cmd.set_status = 1'b1;
                cmd.status     = ST_BINNED;
                state_next     = S_DONE;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.op = OP_CLR_STEP;
                if (stat.clr_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_STARTED;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Output register valid: filled on load, emptied when taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

    // One item at a time: no second accept right after the first
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

endmodule

// ===== src/gpb_dp.sv =====
module gpb_dp #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gpb_pkg::COORD_W-1:0]         cfg_data,
    input  logic [gpb_pkg::IN_W-1:0]            s_tdata,
    input  gpb_pkg::dp_cmd_t                    cmd,
    output gpb_pkg::dp_stat_t                   stat,
    output logic [gpb_pkg::OUT_W-1:0]           m_tdata,
    output logic [2:0]                          m_tuser
);
    import gpb_pkg::*;

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ADDR_W = CELL_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    // Configuration registers
    logic [COORD_W-1:0] north_reg, south_reg, west_reg, east_reg;
    logic [COORD_W-1:0] excl_lat_reg, excl_lng_reg;
    logic [GRID_W-1:0]  rows_cfg_reg, cols_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            north_reg    <= '0;
            south_reg    <= '0;
            west_reg     <= '0;
            east_reg     <= '0;
            rows_cfg_reg <= GRID_W'(1);
            cols_cfg_reg <= GRID_W'(1);
            excl_lat_reg <= '0;
            excl_lng_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NORTH:    north_reg    <= cfg_data;
                REG_SOUTH:    south_reg    <= cfg_data;
                REG_WEST:     west_reg     <= cfg_data;
                REG_EAST:     east_reg     <= cfg_data;
                REG_ROWS:     rows_cfg_reg <= cfg_data[GRID_W-1:0];
                REG_COLS:     cols_cfg_reg <= cfg_data[GRID_W-1:0];
                REG_EXCL_LAT: excl_lat_reg <= cfg_data;
                REG_EXCL_LNG: excl_lng_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Rows and columns in use: zero reads as one, capped at the maximum
    logic [GRID_W-1:0] rows_eff, cols_eff;
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = GRID_W'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = GRID_W'(MAX_ROWS);
        else
            rows_eff = rows_cfg_reg;

        if (cols_cfg_reg == '0)
            cols_eff = GRID_W'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = GRID_W'(MAX_COLS);
        else
            cols_eff = cols_cfg_reg;
    end

    // Latched point
    logic [COORD_W-1:0] lat_reg, lng_reg;
    logic               grp_reg, alloc_reg;

    // Step dividers (restoring, one quotient bit per cycle on each axis)
    logic [COORD_W-1:0]   rdiv_num_reg, cdiv_num_reg;
    logic [GRID_W-1:0]    rdiv_rem_reg, cdiv_rem_reg;
    logic [GRID_W-1:0]    rdiv_den_reg, cdiv_den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [COORD_W-1:0]   row_step_reg, col_step_reg;

    logic [GRID_W:0]    rtrial, ctrial;
    logic               rqbit, cqbit;
    logic [GRID_W-1:0]  rrem_next, crem_next;

    always_comb
    begin
        rtrial    = {rdiv_rem_reg, rdiv_num_reg[COORD_W-1]};
        ctrial    = {cdiv_rem_reg, cdiv_num_reg[COORD_W-1]};
        rqbit     = (rtrial >= {1'b0, rdiv_den_reg});
        cqbit     = (ctrial >= {1'b0, cdiv_den_reg});
        rrem_next = rqbit ? GRID_W'(rtrial - {1'b0, rdiv_den_reg}) : rtrial[GRID_W-1:0];
        crem_next = cqbit ? GRID_W'(ctrial - {1'b0, cdiv_den_reg}) : ctrial[GRID_W-1:0];
    end

    // Edge search state
    logic [ACC_W-1:0]  racc_reg, cacc_reg;
    logic [GRID_W-1:0] ridx_reg, cidx_reg;
    logic              rfound_reg, cfound_reg;

    logic [ACC_W-1:0] lat_x, lng_x, rtop, ctop;
    logic             rhit, chit, rlive, clive;

    always_comb
    begin
        lat_x = ACC_W'(lat_reg);
        lng_x = ACC_W'(lng_reg);
        rtop  = racc_reg + ACC_W'(row_step_reg);
        ctop  = cacc_reg + ACC_W'(col_step_reg);
        rhit  = (lat_x >= racc_reg) && (lat_x <= rtop);
        chit  = (lng_x >= cacc_reg) && (lng_x <= ctop);
        rlive = !rfound_reg && (ridx_reg != rows_eff);
        clive = !cfound_reg && (cidx_reg != cols_eff);
    end

    // Count memory addressing
    logic [CELL_W-1:0] cell_idx;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] clr_addr_reg;
    assign cell_idx  = CELL_W'(32'(ridx_reg) * MAX_COLS + 32'(cidx_reg));
    assign cell_addr = {grp_reg, cell_idx};

    logic [COUNT_BITS-1:0] mem [0:DEPTH-1];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;

    // Saturating increment of the count read back
    assign cnt_sat = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cell_addr;
        mem_wd = cnt_sat;
        if (cmd.op == OP_CLR_STEP)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else if (cmd.op == OP_MEM_WR)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.op == OP_MEM_RD)
        begin
            rd_data_reg <= mem[cell_addr];
        end
    end

    // Control registers of the datapath
    status_t res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg    <= '0;
            clr_addr_reg   <= '0;
            row_step_reg   <= '0;
            col_step_reg   <= '0;
            ridx_reg       <= '0;
            cidx_reg       <= '0;
            rfound_reg     <= 1'b0;
            cfound_reg     <= 1'b0;
            res_status_reg <= ST_BINNED;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    div_cnt_reg <= '0;
                    ridx_reg    <= '0;
                    cidx_reg    <= '0;
                    rfound_reg  <= 1'b0;
                    cfound_reg  <= 1'b0;
                end
                OP_DIV_STEP:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == '1)
                    begin
                        row_step_reg <= {rdiv_num_reg[COORD_W-2:0], rqbit};
                        col_step_reg <= {cdiv_num_reg[COORD_W-2:0], cqbit};
                    end
                end
                OP_CLR_STEP:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
                OP_SRCH_STEP:
                begin
                    if (rlive)
                    begin
                        if (rhit)
                            rfound_reg <= 1'b1;
                        else
                            ridx_reg <= ridx_reg + GRID_W'(1);
                    end
                    if (clive)
                    begin
                        if (chit)
                            cfound_reg <= 1'b1;
                        else
                            cidx_reg <= cidx_reg + GRID_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: point, divider words, accumulators, count
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                lat_reg   <= s_tdata[31:0];
                lng_reg   <= s_tdata[63:32];
                grp_reg   <= s_tdata[64];
                alloc_reg <= s_tdata[65];
                rdiv_num_reg <= (south_reg >= north_reg) ? south_reg - north_reg : '0;
                cdiv_num_reg <= (east_reg >= west_reg) ? east_reg - west_reg : '0;
                rdiv_rem_reg <= '0;
                cdiv_rem_reg <= '0;
                rdiv_den_reg <= rows_eff;
                cdiv_den_reg <= cols_eff;
                racc_reg     <= ACC_W'(north_reg);
                cacc_reg     <= ACC_W'(west_reg);
            end
            OP_DIV_STEP:
            begin
                rdiv_num_reg <= {rdiv_num_reg[COORD_W-2:0], rqbit};
                cdiv_num_reg <= {cdiv_num_reg[COORD_W-2:0], cqbit};
                rdiv_rem_reg <= rrem_next;
                cdiv_rem_reg <= crem_next;
            end
            OP_SRCH_STEP:
            begin
                if (rlive && !rhit)
                    racc_reg <= rtop;
                if (clive && !chit)
                    cacc_reg <= ctop;
            end
            OP_MEM_WR:
            begin
                cnt_reg <= cnt_sat;
            end
            default: ;
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        stat.div_last  = (div_cnt_reg == '1);
        stat.clr_last  = (clr_addr_reg == '1);
        stat.in_box    = (lat_reg >= north_reg) && (lat_reg <= south_reg) &&
                         (lng_reg >= west_reg) && (lng_reg <= east_reg);
        stat.skip      = alloc_reg ||
                         ((lat_reg == excl_lat_reg) && (lng_reg == excl_lng_reg));
        stat.srch_done = !rlive && !clive;
        stat.gap       = !rfound_reg || !cfound_reg;
    end

    // Output register
    status_t            out_status_reg;
    logic [ROWF_W-1:0]  out_row_reg, out_col_reg;
    logic               out_grp_reg;
    logic [OCNT_W-1:0]  out_cnt_reg;
    logic [31:0]        cnt_wide;

    assign cnt_wide = 32'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            if (res_status_reg == ST_BINNED)
            begin
                out_row_reg <= ridx_reg[ROWF_W-1:0];
                out_col_reg <= cidx_reg[ROWF_W-1:0];
                out_grp_reg <= grp_reg;
                out_cnt_reg <= cnt_wide[OCNT_W-1:0];
            end
            else
            begin
                out_row_reg <= '0;
                out_col_reg <= '0;
                out_grp_reg <= 1'b0;
                out_cnt_reg <= '0;
            end
        end
    end

    assign m_tuser = out_status_reg;
    assign m_tdata = {7'd0, out_cnt_reg, out_grp_reg, out_col_reg, out_row_reg};

    // The count write always follows its read
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MEM_WR) |-> ($past(cmd.op) == OP_MEM_RD))
        else $error("count written without a preceding read");

    // A count is read only for a point with both edges found
    a_rd_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MEM_RD) |-> (rfound_reg && cfound_reg))
        else $error("count read without a cell");

endmodule

// ===== src/grid_point_binning.sv =====
// Channel  Dir  Handshake                 Payload
// s        in   s_tvalid / s_tready       s_tdata: lat, lng, disappeared, allocated
//                                         s_tuser: action
// m        out  m_tvalid / m_tready       m_tdata: row, col, group, count
//                                         m_tuser: status
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A binned point runs the edge search, one step per cycle on rows and columns
// together, then a read and a write of the count memory. Outside or skipped
// points go straight from the check to the result. A start item runs the step
// divider, then a clearing sweep over every count memory entry (512 by default),
// then loads the result. After reset the same sweep runs before s_tready rises.
// One item is worked at a time; the result waits in an output register, so the
// next item is taken while m_tready is low.
module grid_point_binning #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] point_lat, [63:32] point_lng, [64] is_disappeared,
    // [65] already_allocated, [71:66] zero
    input  logic [gpb_pkg::IN_W-1:0]      s_tdata,
    // [0] action
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] cell_row, [7:4] cell_col, [8] group, [24:9] cell_count, [31:25] zero
    output logic [gpb_pkg::OUT_W-1:0]     m_tdata,
    // [2:0] status
    output logic [2:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gpb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpb_pkg::COORD_W-1:0]   cfg_data
);
    import gpb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    gpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    gpb_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/sv/tb_grid_point_binning.sv =====
`timescale 1ns / 1ps

module tb_grid_point_binning;
    import gpb_pkg::*;

    localparam int ROWS_MAX       = 16;
    localparam int COLS_MAX       = 16;
    localparam int CELLS          = 2 * ROWS_MAX * COLS_MAX;
    localparam bit [15:0] TALLY_MAX = 16'hFFFF;
    localparam int HOLD_CYCLES    = 600;
    localparam int STALL_LIMIT    = 8000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int PRESSURE_PHASE = 4;
    localparam int CORNER_ITEMS   = 6;
    localparam int DIR_ROWS       = 22;
    localparam int DIR_RESET_ROWS = 3;

    // One input item and one result item
    typedef struct packed {
        bit        action;
        bit [31:0] lat;
        bit [31:0] lng;
        bit        dis;
        bit        alloc;
    } bin_req_t;

    typedef struct packed {
        status_t   status;
        bit [3:0]  row;
        bit [3:0]  col;
        bit        grp;
        bit [15:0] count;
    } bin_res_t;

    typedef struct packed {
        bin_req_t req;
        bit       typed;
        bin_res_t res;
    } dir_row_t;

    localparam bin_res_t PREDICTED   = '0;
    localparam bin_res_t RES_OUTSIDE = '{ST_OUTSIDE, 4'd0, 4'd0, 1'b0, 16'd0};
    localparam bin_res_t RES_SKIPPED = '{ST_SKIPPED, 4'd0, 4'd0, 1'b0, 16'd0};
    localparam bin_res_t RES_GAP     = '{ST_GAP, 4'd0, 4'd0, 1'b0, 16'd0};
    localparam bin_res_t RES_STARTED = '{ST_STARTED, 4'd0, 4'd0, 1'b0, 16'd0};

    // Directed items; the first rows run with the reset register values,
    // the rest with box 100..1002 x 200..2000, 4 x 3 cells, excluded (500,500)
    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{1'b0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1, RES_SKIPPED},
        '{'{1'b0, 32'd1, 32'd0, 1'b0, 1'b0}, 1'b1, RES_OUTSIDE},
        '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, RES_OUTSIDE},
        // no start yet: steps are zero, only the box corner bins
        '{'{1'b0, 32'd100, 32'd200, 1'b0, 1'b0}, 1'b1, '{ST_BINNED, 4'd0, 4'd0, 1'b0, 16'd1}},
        '{'{1'b0, 32'd100, 32'd200, 1'b1, 1'b0}, 1'b1, '{ST_BINNED, 4'd0, 4'd0, 1'b1, 16'd1}},
        '{'{1'b0, 32'd100, 32'd200, 1'b1, 1'b0}, 1'b1, '{ST_BINNED, 4'd0, 4'd0, 1'b1, 16'd2}},
        '{'{1'b0, 32'd500, 32'd700, 1'b0, 1'b0}, 1'b1, RES_GAP},
        '{'{1'b0, 32'd500, 32'd500, 1'b1, 1'b0}, 1'b1, RES_SKIPPED},
        '{'{1'b0, 32'd101, 32'd200, 1'b0, 1'b1}, 1'b1, RES_SKIPPED},
        '{'{1'b0, 32'd99, 32'd500, 1'b0, 1'b0}, 1'b1, RES_OUTSIDE},
        '{'{1'b0, 32'd1003, 32'd500, 1'b0, 1'b0}, 1'b1, RES_OUTSIDE},
        '{'{1'b0, 32'd500, 32'd199, 1'b0, 1'b0}, 1'b1, RES_OUTSIDE},
        '{'{1'b0, 32'd500, 32'd2001, 1'b0, 1'b0}, 1'b1, RES_OUTSIDE},
        // box test ahead of the allocated test
        '{'{1'b0, 32'd99, 32'd500, 1'b0, 1'b1}, 1'b1, RES_OUTSIDE},
        '{'{1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1}, 1'b1, RES_STARTED},
        // steps now 225 x 600, counts cleared
        '{'{1'b0, 32'd100, 32'd200, 1'b0, 1'b0}, 1'b1, '{ST_BINNED, 4'd0, 4'd0, 1'b0, 16'd1}},
        '{'{1'b0, 32'd325, 32'd800, 1'b0, 1'b0}, 1'b0, PREDICTED},
        '{'{1'b0, 32'd326, 32'd801, 1'b1, 1'b0}, 1'b0, PREDICTED},
        '{'{1'b0, 32'd1000, 32'd2000, 1'b0, 1'b0}, 1'b0, PREDICTED},
        // truncation gap past the last row edge
        '{'{1'b0, 32'd1001, 32'd500, 1'b0, 1'b0}, 1'b1, RES_GAP},
        '{'{1'b0, 32'd1002, 32'd2000, 1'b1, 1'b0}, 1'b1, RES_GAP},
        '{'{1'b0, 32'd550, 32'd1399, 1'b1, 1'b0}, 1'b0, PREDICTED}
    };

    // Idle plans per random phase, percent of cycles
    int src_plan  [RAND_PHASES] = '{0, 83, 0, 22, 0, 0, 83, 22};
    int sink_plan [RAND_PHASES] = '{0, 0, 83, 22, 0, 83, 0, 22};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data  = '0;

    // Mirror of the block's registers and state
    bit [31:0] box_north, box_south, box_west, box_east;
    bit [31:0] excl_lat, excl_lng;
    bit [4:0]  grid_rows_reg = 5'd1;
    bit [4:0]  grid_cols_reg = 5'd1;
    bit [31:0] lat_step, lng_step;
    bit [15:0] cell_tally [CELLS];

    bin_res_t expected_bins [$];

    int err_cnt        = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    bit hold_arm       = 1'b0;
    int quiet_cycles   = 0;

    always #5 clk = ~clk;

    grid_point_binning i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Rows/columns in use: zero means one, above the maximum means the maximum
    function automatic int unsigned grid_span(bit [4:0] v, int unsigned lim);
        if (v == 5'd0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    // First slot whose inclusive edges hold v, or n when none does
    function automatic int unsigned slot_of(bit [31:0] v, bit [31:0] lo, bit [31:0] step,
                                            int unsigned n);
        bit [63:0] edge_lo;
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            edge_lo = {32'b0, lo} + 64'(i) * {32'b0, step};
            if ({32'b0, v} >= edge_lo && {32'b0, v} <= edge_lo + {32'b0, step})
                return i;
        end
        return n;
    endfunction

    function automatic bin_res_t predict_bin(bin_req_t req);
        bin_res_t res;
        int unsigned nr, nc, fr, fc, idx;
        res = '0;
        nr  = grid_span(grid_rows_reg, ROWS_MAX);
        nc  = grid_span(grid_cols_reg, COLS_MAX);
        if (req.action)
        begin
            foreach (cell_tally[i])
                cell_tally[i] = '0;
            lat_step   = (box_south >= box_north) ? (box_south - box_north) / nr : '0;
            lng_step   = (box_east >= box_west) ? (box_east - box_west) / nc : '0;
            res.status = ST_STARTED;
        end
        else if (req.lat < box_north || req.lat > box_south ||
                 req.lng < box_west || req.lng > box_east)
            res.status = ST_OUTSIDE;
        else if (req.alloc || (req.lat == excl_lat && req.lng == excl_lng))
            res.status = ST_SKIPPED;
        else
        begin
            fr = slot_of(req.lat, box_north, lat_step, nr);
            fc = slot_of(req.lng, box_west, lng_step, nc);
            if (fr >= nr || fc >= nc)
                res.status = ST_GAP;
            else
            begin
                idx = 32'(req.dis) * ROWS_MAX * COLS_MAX + fr * COLS_MAX + fc;
                if (cell_tally[idx] != TALLY_MAX)
                    cell_tally[idx]++;
                res.status = ST_BINNED;
                res.row    = fr[3:0];
                res.col    = fc[3:0];
                res.grp    = req.dis;
                res.count  = cell_tally[idx];
            end
        end
        return res;
    endfunction

    // Random point: mostly inside the box, some on cell edges, some on the
    // excluded point, some anywhere, a few starts
    function automatic bin_req_t make_req();
        bin_req_t r;
        int unsigned pick, k;
        bit [63:0] e;
        r.action = 1'b0;
        r.lat    = $urandom_range(box_south, box_north);
        r.lng    = $urandom_range(box_east, box_west);
        r.dis    = 1'($urandom_range(0, 1));
        r.alloc  = ($urandom_range(0, 9) == 0);
        pick     = $urandom_range(0, 99);
        if (pick < 6)
            r.action = 1'b1;
        else if (pick < 18)
        begin
            r.lat = $urandom;
            r.lng = $urandom;
        end
        else if (pick < 26)
        begin
            r.lat = excl_lat;
            r.lng = excl_lng;
        end
        else if (pick < 50)
        begin
            k = $urandom_range(0, grid_span(grid_rows_reg, ROWS_MAX));
            e = {32'b0, box_north} + 64'(k) * {32'b0, lat_step} +
                64'($urandom_range(0, 2)) - 64'd1;
            r.lat = e[31:0];
            k = $urandom_range(0, grid_span(grid_cols_reg, COLS_MAX));
            e = {32'b0, box_west} + 64'(k) * {32'b0, lng_step} +
                64'($urandom_range(0, 2)) - 64'd1;
            r.lng = e[31:0];
        end
        return r;
    endfunction

    task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_NORTH:    box_north     = val;
            REG_SOUTH:    box_south     = val;
            REG_WEST:     box_west      = val;
            REG_EAST:     box_east      = val;
            REG_ROWS:     grid_rows_reg = val[4:0];
            REG_COLS:     grid_cols_reg = val[4:0];
            REG_EXCL_LAT: excl_lat      = val;
            REG_EXCL_LNG: excl_lng      = val;
            default: ;
        endcase
    endtask

    task automatic write_box(input bit [31:0] n, s, w, e, input bit [4:0] nr, nc,
                             input bit [31:0] xl, xg);
        write_reg(REG_NORTH, n);
        write_reg(REG_SOUTH, s);
        write_reg(REG_WEST, w);
        write_reg(REG_EAST, e);
        write_reg(REG_ROWS, {27'b0, nr});
        write_reg(REG_COLS, {27'b0, nc});
        write_reg(REG_EXCL_LAT, xl);
        write_reg(REG_EXCL_LNG, xg);
        cfg_valid <= 1'b0;
    endtask

    // Register set for a random phase: full range, random, clamped counts
    // with a narrow box, or random counts with each axis inverted at random
    task automatic set_phase_config(int kind);
        bit [31:0] a, b, c, d, t;
        bit [4:0]  nr, nc;
        a  = $urandom;
        b  = $urandom;
        c  = $urandom;
        d  = $urandom;
        nr = 5'($urandom_range(1, 16));
        nc = 5'($urandom_range(1, 16));
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (c > d)
        begin
            t = c; c = d; d = t;
        end
        case (kind)
            0:
            begin
                a  = '0; b = '1; c = '0; d = '1;
                nr = 5'd16;
                nc = 5'd16;
            end
            2:
            begin
                a  = $urandom_range(32'hFFFF_FF00, 0);
                b  = a + $urandom_range(0, 40);
                c  = $urandom_range(32'hFFFF_FF00, 0);
                d  = c + $urandom_range(0, 40);
                nr = 5'd0;
                nc = 5'd31;
            end
            3:
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    t = a; a = b; b = t;
                end
                if ($urandom_range(0, 2) != 1)
                begin
                    t = c; c = d; d = t;
                end
                nr = 5'($urandom_range(0, 31));
                nc = 5'($urandom_range(0, 31));
            end
            default: ;
        endcase
        write_box(a, b, c, d, nr, nc, $urandom_range(b, a), $urandom_range(d, c));
    endtask

    task automatic send_req(bin_req_t req, bit typed, bin_res_t typed_res);
        bin_res_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, req.alloc, req.dis, req.lng, req.lat};
        s_tuser  <= req.action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_bin(req);
        expected_bins.push_back(typed ? typed_res : pred);
    endtask

    // Every item gives one result, so an empty queue means the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void check_bin();
        bin_res_t want;
        if (expected_bins.size() == 0)
        begin
            $display("%0t: result with none expected, status %0d", $time, m_tuser);
            err_cnt++;
        end
        else
        begin
            want = expected_bins.pop_front();
            check_field("status", 32'(want.status), 32'(m_tuser));
            check_field("cell_row", 32'(want.row), 32'(m_tdata[3:0]));
            check_field("cell_col", 32'(want.col), 32'(m_tdata[7:4]));
            check_field("group", 32'(want.grp), 32'(m_tdata[8]));
            check_field("cell_count", 32'(want.count), 32'(m_tdata[24:9]));
        end
    endfunction

    // Result side: check accepted items, random stalls, long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_bin();
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_arm)
            begin
                hold_arm  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bin_req_t req;
        int ph, n, i;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_RESET_ROWS)
            begin
                drain();
                write_box(32'd100, 32'd1002, 32'd200, 32'd2000, 5'd4, 5'd3,
                          32'd500, 32'd500);
            end
            send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
        end

        // Random phases, each with its own register set and idle plan
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            src_idle_pct   = src_plan[ph];
            sink_stall_pct = sink_plan[ph];
            set_phase_config(ph % 4);
            if ($urandom_range(0, 3) != 0)
            begin
                req        = make_req();
                req.action = 1'b1;
                send_req(req, 1'b0, PREDICTED);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == PRESSURE_PHASE && n == 5)
                    hold_arm = 1'b1;
                send_req(make_req(), 1'b0, PREDICTED);
            end
        end

        // One cell at the top corner of the coordinate range, both groups
        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_box('1, '1, '1, '1, 5'd1, 5'd1, '0, '0);
        send_req('{1'b1, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1, RES_STARTED);
        for (n = 0; n < CORNER_ITEMS; n++)
            send_req('{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, n >= CORNER_ITEMS - 3, 1'b0},
                     1'b0, PREDICTED);

        drain();
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
